### rtl/bq_pkg.sv
// Package for the biquad ADC-to-DAC filter: widths, fixed-point formats,
// register indexes and reset values. Depends on nothing; the top level and
// the checker import it.
`timescale 1ns / 1ps

package bq_pkg;

    // Converter sample width and the fixed-point formats built on it.
    localparam int SAMPLE_BITS = 12;
    localparam int COEF_W      = 24;              // Q3.20 coefficients, Q12.12 scale
    localparam int COEF_FRAC   = 20;
    localparam int OP_A_W      = COEF_W + 1;      // coefficient or unsigned scale, signed
    localparam int DATA_W      = 32;              // Q8.24 history word
    localparam int PROD_W      = OP_A_W + DATA_W;
    localparam int ACC_W       = PROD_W + 1;
    localparam int ACC_FRAC    = 44;
    localparam int HIST_FRAC   = 24;
    localparam int SCALE_FRAC  = 12;
    localparam int OUT_FRAC    = HIST_FRAC + SCALE_FRAC;
    localparam int ROUND_SHIFT = ACC_FRAC - HIST_FRAC;
    // Lift of a Q3.20 x Q1.(SAMPLE_BITS-1) product to the accumulator format.
    localparam int FF_SHIFT    = ACC_FRAC - COEF_FRAC - (SAMPLE_BITS - 1);

    localparam int CFG_IDX_W   = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FEED0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd5;

    // Reset values: unity feed-forward gain, no feedback, default scale.
    localparam logic [COEF_W-1:0] FEED0_RESET = 24'd1048576;
    localparam logic [COEF_W-1:0] SCALE_RESET = 24'd14421361;

    // Rounding and clamping constants.
    localparam logic signed [ACC_W-1:0] ACC_ROUND =
        ACC_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] OUT_HALF = ACC_W'(1) <<< (OUT_FRAC - 1);
    localparam logic signed [ACC_W-1:0] OUT_OFFS =
        (ACC_W'(1) <<< (OUT_FRAC + SAMPLE_BITS - 1)) + OUT_HALF;
    localparam logic signed [ACC_W-1:0] OUT_TOP =
        ((ACC_W'(1) <<< (OUT_FRAC + SAMPLE_BITS)) - (ACC_W'(1) <<< OUT_FRAC)) + OUT_HALF;
    localparam logic [SAMPLE_BITS-1:0] CODE_MAX = {SAMPLE_BITS{1'b1}};

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [DATA_W-1:0]      t_hist;

endpackage

### rtl/biquad_iir_adc_to_dac.sv
// Direct Form I biquad from a 12-bit ADC code to a 12-bit DAC code.
// Uses bq_pkg for formats and constants; one shared multiplier does all products.
`timescale 1ns / 1ps

// Usage
//   Input channel: i_in_valid / o_in_stall carry i_mode and i_adc_code. Mode 0
//   filters one sample and gives one result; mode 1 clears the four history
//   words at once and gives no result.
//   Output channel: o_out_valid / i_out_stall carry o_dac_code.
//   Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
//   (feed0, feed1, feed2, back1, back2, scale); other indexes are ignored.
//   Write only while the block is idle.
//   Sequence: after acceptance, a filter transaction runs a multiply step
//   for each of the five taps, then one to add the last product, one to
//   round and saturate, one for the output scale product and one to clamp.
//   Occupancy: no new sample is accepted until the previous one has left its
//   clamp step, as the single shared 25 x 32 multiplier serves all six
//   products in turn. A clear leaves the block idle.
//   Reset (synchronous, active low) loads the register defaults, zeroes the
//   history and empties the output register.
//   While the receiver stalls, the result is held in the output register; the
//   next sample is still accepted and waits before its clamp step.
module biquad_iir_adc_to_dac
    import bq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_mode,
    input  logic [SAMPLE_BITS-1:0] i_adc_code,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SAMPLE_BITS-1:0] o_dac_code,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [COEF_W-1:0]      i_cfg_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_LAST  = 3'd2;
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_CLAMP = 3'd5;

    // Tap steps of the multiply-accumulate pass.
    localparam logic [2:0] STEP_FEED0 = 3'd0;
    localparam logic [2:0] STEP_FEED1 = 3'd1;
    localparam logic [2:0] STEP_FEED2 = 3'd2;
    localparam logic [2:0] STEP_BACK1 = 3'd3;
    localparam logic [2:0] STEP_BACK2 = 3'd4;

    logic [2:0]               r_state, n_state;
    logic [2:0]               r_step;
    logic                     r_sub;
    logic [COEF_W-1:0]        r_feed0, r_feed1, r_feed2, r_back1, r_back2, r_scale;
    t_sample                  r_x, r_in_hist1, r_in_hist2;
    t_hist                    r_out_hist1, r_out_hist2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic [SAMPLE_BITS-1:0]   r_dac;

    logic signed [OP_A_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  y_full;
    t_hist                    y_sat;
    logic signed [ACC_W-1:0]  dac_full;
    logic [SAMPLE_BITS-1:0]   dac_code;
    logic                     in_take;
    logic                     out_free;

    assign in_take  = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign prod_ext = ACC_W'(r_prod);

    // Operand select for the shared multiplier.
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (r_state == ST_SCALE) begin
            op_a = signed'({1'b0, r_scale});
            op_b = r_out_hist1;
        end else begin
            case (r_step)
                STEP_FEED0: begin
                    op_a = OP_A_W'(signed'(r_feed0));
                    op_b = DATA_W'(r_x) <<< FF_SHIFT;
                end
                STEP_FEED1: begin
                    op_a = OP_A_W'(signed'(r_feed1));
                    op_b = DATA_W'(r_in_hist1) <<< FF_SHIFT;
                end
                STEP_FEED2: begin
                    op_a = OP_A_W'(signed'(r_feed2));
                    op_b = DATA_W'(r_in_hist2) <<< FF_SHIFT;
                end
                STEP_BACK1: begin
                    op_a = OP_A_W'(signed'(r_back1));
                    op_b = r_out_hist1;
                end
                STEP_BACK2: begin
                    op_a = OP_A_W'(signed'(r_back2));
                    op_b = r_out_hist2;
                end
                default: begin
                    op_a = '0;
                    op_b = '0;
                end
            endcase
        end
    end

    // Round half up to Q8.24 (the half is preloaded) and saturate to 32 bits.
    always_comb begin
        y_full = r_acc >>> ROUND_SHIFT;
        if (y_full > SAT_HI) begin
            y_sat = DATA_W'(SAT_HI);
        end else if (y_full < SAT_LO) begin
            y_sat = DATA_W'(SAT_LO);
        end else begin
            y_sat = DATA_W'(y_full);
        end
    end

    // Add midscale and the rounding half, then clamp to the code range.
    always_comb begin
        dac_full = prod_ext + OUT_OFFS;
        if (dac_full < OUT_HALF) begin
            dac_code = '0;
        end else if (dac_full > OUT_TOP) begin
            dac_code = CODE_MAX;
        end else begin
            dac_code = SAMPLE_BITS'(dac_full >>> OUT_FRAC);
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take && !i_mode) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_step == STEP_BACK2) begin
                    n_state = ST_LAST;
                end
            end
            ST_LAST:  n_state = ST_ROUND;
            ST_ROUND: n_state = ST_SCALE;
            ST_SCALE: n_state = ST_CLAMP;
            ST_CLAMP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state, configuration and filter history.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= STEP_FEED0;
            r_out_valid <= 1'b0;
            r_feed0     <= FEED0_RESET;
            r_feed1     <= '0;
            r_feed2     <= '0;
            r_back1     <= '0;
            r_back2     <= '0;
            r_scale     <= SCALE_RESET;
            r_in_hist1  <= '0;
            r_in_hist2  <= '0;
            r_out_hist1 <= '0;
            r_out_hist2 <= '0;
        end else begin
            r_state <= n_state;

            // Register writes; unknown indexes are dropped.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FEED0: r_feed0 <= i_cfg_data;
                    CFG_FEED1: r_feed1 <= i_cfg_data;
                    CFG_FEED2: r_feed2 <= i_cfg_data;
                    CFG_BACK1: r_back1 <= i_cfg_data;
                    CFG_BACK2: r_back2 <= i_cfg_data;
                    CFG_SCALE: r_scale <= i_cfg_data;
                    default:   ;
                endcase
            end

            // Tap counter for the multiply pass.
            if (r_state == ST_MAC) begin
                r_step <= (r_step == STEP_BACK2) ? STEP_FEED0 : r_step + 3'd1;
            end

            // A clear transaction wipes the history at once.
            if (in_take && i_mode) begin
                r_in_hist1  <= '0;
                r_in_hist2  <= '0;
                r_out_hist1 <= '0;
                r_out_hist2 <= '0;
            end

            // Shift the history once the new output is known.
            if (r_state == ST_ROUND) begin
                r_in_hist2  <= r_in_hist1;
                r_in_hist1  <= r_x;
                r_out_hist2 <= r_out_hist1;
                r_out_hist1 <= y_sat;
            end

            // Output register: load on clamp, empty when the receiver takes it.
            if (r_state == ST_CLAMP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers: sample, product, accumulator and result code.
    always_ff @(posedge i_clk) begin
        // Centre the code at midscale by flipping its top bit.
        if (in_take) begin
            r_x <= signed'({~i_adc_code[SAMPLE_BITS-1], i_adc_code[SAMPLE_BITS-2:0]});
        end

        if (r_state == ST_MAC || r_state == ST_SCALE) begin
            r_prod <= PROD_W'(op_a) * PROD_W'(op_b);
        end

        // The accumulator adds, or for a feedback tap subtracts, the product of the previous tap.
        if (r_state == ST_MAC) begin
            r_sub <= (r_step == STEP_BACK1) || (r_step == STEP_BACK2);
            if (r_step == STEP_FEED0) begin
                r_acc <= ACC_ROUND;
            end else begin
                r_acc <= r_sub ? r_acc - prod_ext : r_acc + prod_ext;
            end
        end else if (r_state == ST_LAST) begin
            r_acc <= r_sub ? r_acc - prod_ext : r_acc + prod_ext;
        end

        if (r_state == ST_CLAMP && out_free) begin
            r_dac <= dac_code;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_dac_code  = r_dac;

endmodule

### rtl/bq_checker.sv
// Port-level checker for the biquad ADC-to-DAC filter, bound to the top level.
// Uses bq_pkg for the port widths.
`timescale 1ns / 1ps

module bq_checker
    import bq_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_stall,
    input logic                   i_mode,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input logic [SAMPLE_BITS-1:0] o_dac_code
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_dac_code))
        else $error("result changed or dropped while stalled");

    // A filter transaction occupies the block on the next cycle.
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_mode |=> o_in_stall)
        else $error("block free right after a filter transaction");

    // A clear transaction leaves the block free on the next cycle.
    a_clear_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_mode |=> !o_in_stall)
        else $error("block busy after a clear transaction");

    // A filter result never shows up in the cycle right after acceptance.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_mode |=> !$rose(o_out_valid))
        else $error("result appeared too early");

    // Reset leaves the block empty and ready.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not empty after reset");

endmodule

bind biquad_iir_adc_to_dac bq_checker u_bq_checker (.*);
